/* hw/rtl/pgmb_pkg.sv */
// ----------------------------------------------------------------------------
// pgmb_pkg
// Shared types and constants of the planar glyph mask blitter.
// ----------------------------------------------------------------------------
package pgmb_pkg;

	// page geometry
	localparam int PLANE_COUNT = 4;
	localparam int PLANE_BYTES = 8192;
	localparam int ROW_PITCH   = 40;
	localparam int ADDR_W      = $clog2(PLANE_BYTES);

	// result queue depth
	localparam int RES_DEPTH = 3;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);

	// configuration register indexes
	localparam logic [1:0] REG_FIRST_OFFSET  = 2'd0;
	localparam logic [1:0] REG_ROWS_IN_GLYPH = 2'd1;
	localparam logic [1:0] REG_SET_LANE_MASK = 2'd2;
	localparam logic [1:0] REG_MODE_WORD     = 2'd3;

	// input actions
	localparam logic [1:0] ACT_GLYPH_ROW  = 2'd0;
	localparam logic [1:0] ACT_WRITE_BYTE = 2'd1;
	localparam logic [1:0] ACT_READ_BYTE  = 2'd2;

	// mode word fields
	localparam logic [15:0] MODE_SET_BITS = 16'h00F0;

	// memory operation kinds
	typedef logic [1:0] op_kind_t;
	localparam op_kind_t OP_NONE = 2'd0;
	localparam op_kind_t OP_RMW  = 2'd1;
	localparam op_kind_t OP_WR   = 2'd2;
	localparam op_kind_t OP_RD   = 2'd3;

	// one memory operation issued by the sequencer
	typedef struct packed {
		logic                   valid;
		op_kind_t               kind;
		logic [ADDR_W-1:0]      addr;
		logic [1:0]             plane;
		logic [7:0]             bits;    // mask byte or write data
		logic [PLANE_COUNT-1:0] set;
		logic                   tail;    // last operation of the item
		logic                   status;
		logic                   last;
	} op_t;

	// one result item
	typedef struct packed {
		logic       status;
		logic [7:0] read_byte;
		logic       last_row;
	} res_t;

endpackage

/* hw/rtl/pgmb_plane_ram.sv */
// ----------------------------------------------------------------------------
// pgmb_plane_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pgmb_plane_ram #(
	parameter int ADDR_W = 13,
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, old data on a same-address write
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/pgmb_seq.sv */
// ----------------------------------------------------------------------------
// pgmb_seq
// Input acceptance, configuration registers, row counter and operation issue.
// ----------------------------------------------------------------------------
module pgmb_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic [7:0]         glyph_byte,
	input  logic [1:0]         plane_sel,
	input  logic [12:0]        byte_address,
	input  logic [7:0]         write_byte,
	input  logic               room,
	output pgmb_pkg::op_t      op
);

	logic [12:0]                      first_offset_q;
	logic [7:0]                       rows_in_glyph_q;
	logic [pgmb_pkg::PLANE_COUNT-1:0] set_lane_mask_q;
	logic [15:0]                      mode_word_q;

	logic                             busy_q;
	logic [1:0]                       byte_q;
	logic [pgmb_pkg::ADDR_W-1:0]      base_q;
	logic [31:0]                      mask_q;
	logic [pgmb_pkg::PLANE_COUNT-1:0] set_q;
	logic                             last_q;
	logic [7:0]                       row_q;

	logic                             accept;
	logic                             off_ok;
	logic [12:0]                      room_bytes;
	logic [15:0]                      span;
	logic                             fits;
	logic                             row_ok;
	logic [15:0]                      row_off;
	logic [15:0]                      base_sum;
	logic [pgmb_pkg::ADDR_W-1:0]      base_new;
	logic [31:0]                      mask_new;
	logic [pgmb_pkg::PLANE_COUNT-1:0] set_new;
	logic [7:0]                       row_next;
	logic                             last_new;
	logic                             byte_oob;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_offset_q  <= '0;
			rows_in_glyph_q <= '0;
			set_lane_mask_q <= '0;
			mode_word_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pgmb_pkg::REG_FIRST_OFFSET:  first_offset_q  <= cfg_data[12:0];
				pgmb_pkg::REG_ROWS_IN_GLYPH: rows_in_glyph_q <= cfg_data[7:0];
				pgmb_pkg::REG_SET_LANE_MASK:
					set_lane_mask_q <= cfg_data[pgmb_pkg::PLANE_COUNT-1:0];
				pgmb_pkg::REG_MODE_WORD:     mode_word_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// glyph bounds: (rows - 1) * pitch must stay within the room left
	assign off_ok     = first_offset_q <= 13'(pgmb_pkg::PLANE_BYTES - 4);
	assign room_bytes = 13'(pgmb_pkg::PLANE_BYTES - 4) - first_offset_q;
	assign span       = 16'(rows_in_glyph_q - 8'd1) * 16'(pgmb_pkg::ROW_PITCH);
	assign fits       = (rows_in_glyph_q != 8'd0) && off_ok && (span <= 16'(room_bytes));
	assign row_ok     = fits && (row_q < rows_in_glyph_q);

	// row address, mask and per-plane set mode
	assign row_off  = 16'(row_q) * 16'(pgmb_pkg::ROW_PITCH);
	assign base_sum = 16'(first_offset_q) + row_off;
	assign base_new = base_sum[pgmb_pkg::ADDR_W-1:0];
	assign mask_new = {glyph_byte, 24'd0} >> mode_word_q[15:12];
	assign set_new  = set_lane_mask_q
		| {pgmb_pkg::PLANE_COUNT{|(mode_word_q & pgmb_pkg::MODE_SET_BITS)}};
	assign row_next = row_q + 8'd1;
	assign last_new = row_next >= rows_in_glyph_q;

	// byte access range
	assign byte_oob = (32'(plane_sel) >= pgmb_pkg::PLANE_COUNT)
		|| (32'(byte_address) >= pgmb_pkg::PLANE_BYTES);

	assign in_ready = !busy_q && room;
	assign accept   = in_valid && in_ready;

	// operation issue
	always_comb begin
		op        = '0;
		op.kind   = pgmb_pkg::OP_NONE;
		op.addr   = byte_address;
		op.plane  = plane_sel;
		op.bits   = write_byte;
		op.set    = set_new;
		if (busy_q) begin
			op.kind  = pgmb_pkg::OP_RMW;
			op.addr  = base_q;
			op.bits  = mask_q[31:24];
			op.set   = set_q;
			op.tail  = byte_q == 2'd3;
			op.last  = last_q;
			op.valid = (byte_q != 2'd3) || room;
		end else if (accept) begin
			op.valid = 1'b1;
			op.tail  = 1'b1;
			unique case (action)
				pgmb_pkg::ACT_GLYPH_ROW: begin
					if (row_ok) begin
						op.kind = pgmb_pkg::OP_RMW;
						op.addr = base_new;
						op.bits = mask_new[31:24];
						op.tail = 1'b0;
					end else begin
						op.status = 1'b1;
					end
				end
				pgmb_pkg::ACT_WRITE_BYTE: begin
					if (byte_oob) begin
						op.status = 1'b1;
					end else begin
						op.kind = pgmb_pkg::OP_WR;
					end
				end
				pgmb_pkg::ACT_READ_BYTE: begin
					if (byte_oob) begin
						op.status = 1'b1;
					end else begin
						op.kind = pgmb_pkg::OP_RD;
					end
				end
				default: ;
			endcase
		end
	end

	// glyph row walk over four bytes, row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			byte_q <= '0;
			row_q  <= '0;
			last_q <= 1'b0;
		end else if (busy_q) begin
			if (op.valid) begin
				byte_q <= byte_q + 2'd1;
				if (byte_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end
		end else if (accept && action == pgmb_pkg::ACT_GLYPH_ROW) begin
			if (row_ok) begin
				busy_q <= 1'b1;
				byte_q <= 2'd1;
				last_q <= last_new;
				row_q  <= last_new ? 8'd0 : row_next;
			end else begin
				row_q <= '0;
			end
		end
	end

	// glyph row payload
	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (op.valid) begin
				base_q <= base_q + pgmb_pkg::ADDR_W'(1);
				mask_q <= mask_q << 8;
			end
		end else begin
			base_q <= base_new + pgmb_pkg::ADDR_W'(1);
			mask_q <= mask_new << 8;
			set_q  <= set_new;
		end
	end

endmodule

/* hw/rtl/pgmb_rmw.sv */
// ----------------------------------------------------------------------------
// pgmb_rmw
// Plane memories with one read-modify-write stage and same-address forwarding.
// ----------------------------------------------------------------------------
module pgmb_rmw (
	input  logic            clk,
	input  logic            arst_n,
	input  pgmb_pkg::op_t   op,
	output logic            res_valid,
	output pgmb_pkg::res_t  res,
	output logic            tail_s1
);

	pgmb_pkg::op_t op_s1;
	logic [7:0]    rdata      [pgmb_pkg::PLANE_COUNT];
	logic [7:0]    cur        [pgmb_pkg::PLANE_COUNT];
	logic [7:0]    wdata      [pgmb_pkg::PLANE_COUNT];
	logic          we         [pgmb_pkg::PLANE_COUNT];
	logic          fwd_hit_s1 [pgmb_pkg::PLANE_COUNT];
	logic [7:0]    fwd_data_s1[pgmb_pkg::PLANE_COUNT];

	// operation stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else begin
			op_s1 <= op;
		end
	end

	for (genvar p = 0; p < pgmb_pkg::PLANE_COUNT; p++) begin : g_plane
		// byte merge and write enable
		always_comb begin
			cur[p] = fwd_hit_s1[p] ? fwd_data_s1[p] : rdata[p];
			we[p]  = op_s1.valid && ((op_s1.kind == pgmb_pkg::OP_RMW)
				|| (op_s1.kind == pgmb_pkg::OP_WR && 32'(op_s1.plane) == p));
			if (op_s1.kind == pgmb_pkg::OP_WR) begin
				wdata[p] = op_s1.bits;
			end else begin
				wdata[p] = (cur[p] & ~op_s1.bits) | (op_s1.set[p] ? op_s1.bits : 8'd0);
			end
		end

		// forward a write that meets a read of the same byte
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				fwd_hit_s1[p] <= 1'b0;
			end else begin
				fwd_hit_s1[p] <= we[p] && (op.addr == op_s1.addr);
			end
		end

		always_ff @(posedge clk) begin
			fwd_data_s1[p] <= wdata[p];
		end

		pgmb_plane_ram #(
			.ADDR_W(pgmb_pkg::ADDR_W),
			.DATA_W(8)
		) u_ram (
			.clk   (clk),
			.we    (we[p]),
			.waddr (op_s1.addr),
			.wdata (wdata[p]),
			.raddr (op.addr),
			.rdata (rdata[p])
		);
	end

	// result of the item's last operation
	assign tail_s1       = op_s1.valid && op_s1.tail;
	assign res_valid     = tail_s1;
	assign res.status    = op_s1.status;
	assign res.last_row  = op_s1.last;
	assign res.read_byte = (op_s1.kind == pgmb_pkg::OP_RD) ? cur[op_s1.plane] : 8'd0;

endmodule

/* hw/rtl/pgmb_out_fifo.sv */
// ----------------------------------------------------------------------------
// pgmb_out_fifo
// Small result queue in front of the output stream.
// ----------------------------------------------------------------------------
module pgmb_out_fifo (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  pgmb_pkg::res_t             push_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output pgmb_pkg::res_t             out_data,
	output logic [pgmb_pkg::RES_PTR_W:0] count
);

	pgmb_pkg::res_t                  entry_q [pgmb_pkg::RES_DEPTH];
	logic [pgmb_pkg::RES_PTR_W-1:0]  wr_q;
	logic [pgmb_pkg::RES_PTR_W-1:0]  rd_q;
	logic [pgmb_pkg::RES_PTR_W:0]    count_q;
	logic                            pop;

	assign out_valid = count_q != '0;
	assign out_data  = entry_q[rd_q];
	assign count     = count_q;
	assign pop       = out_valid && out_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (32'(wr_q) == pgmb_pkg::RES_DEPTH - 1) ? '0
					: wr_q + pgmb_pkg::RES_PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (32'(rd_q) == pgmb_pkg::RES_DEPTH - 1) ? '0
					: rd_q + pgmb_pkg::RES_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (pgmb_pkg::RES_PTR_W + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (pgmb_pkg::RES_PTR_W + 1)'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

endmodule

/* hw/rtl/planar_glyph_mask_blit.sv */
// ----------------------------------------------------------------------------
// planar_glyph_mask_blit
// Glyph rows masked into every bitplane of a planar page in block memory.
// ----------------------------------------------------------------------------
// results: a byte write or read gives its result through the operation stage
// register and the result queue, a glyph row after the last of its four bytes
// throughput: one byte action per cycle while the result queue has room; a glyph
// row holds off input while its bytes pass each byte-wide plane's single write port
// reset: clears registers, row counter and result queue; page memory is not
// cleared and holds unknown data until written
module planar_glyph_mask_blit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // glyph_byte, plane_sel, byte_address, write_byte
	input  logic [1:0]  s_axis_tuser,  // action
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // read_byte
	output logic        m_axis_tuser,  // status
	output logic        m_axis_tlast   // last_row
);

	pgmb_pkg::op_t                         op;
	pgmb_pkg::res_t                        res;
	pgmb_pkg::res_t                        out_res;
	logic                                  res_valid;
	logic                                  tail_s1;
	logic                                  room;
	logic [pgmb_pkg::RES_PTR_W:0]          fifo_count;

	// the next result may only be issued while the queue can still take it
	assign room = ({1'b0, fifo_count} + {{(pgmb_pkg::RES_PTR_W + 1){1'b0}}, tail_s1})
		<= (pgmb_pkg::RES_PTR_W + 2)'(pgmb_pkg::RES_DEPTH - 1);

	pgmb_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.action       (s_axis_tuser),
		.glyph_byte   (s_axis_tdata[7:0]),
		.plane_sel    (s_axis_tdata[9:8]),
		.byte_address (s_axis_tdata[22:10]),
		.write_byte   (s_axis_tdata[30:23]),
		.room         (room),
		.op           (op)
	);

	pgmb_rmw u_rmw (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.res_valid (res_valid),
		.res       (res),
		.tail_s1   (tail_s1)
	);

	pgmb_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_res),
		.count     (fifo_count)
	);

	// result fields onto the stream
	assign m_axis_tdata = out_res.read_byte;
	assign m_axis_tuser = out_res.status;
	assign m_axis_tlast = out_res.last_row;

endmodule

/* dv/planar_glyph_mask_blit_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_glyph_mask_blit_checker
// Watches the register port and both streams of the glyph blitter, keeps its
// own copy of the page and registers, and compares every result transfer
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module planar_glyph_mask_blit_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] in_data,  // glyph_byte, plane_sel, byte_address, write_byte
	input  logic [1:0]  in_kind,  // action
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  out_data, // read_byte
	input  logic        out_status,
	input  logic        out_last,
	output int          mismatches,
	output int          outstanding
);
	import pgmb_pkg::*;

	// shadow registers and row position
	logic [12:0] off_cfg   = '0;
	logic [7:0]  rows_cfg  = '0;
	logic [3:0]  lanes_cfg = '0;
	logic [15:0] mode_cfg  = '0;
	logic [7:0]  row_pos   = '0;

	// shadow page, all planes back to back
	logic [7:0] page_copy [PLANE_COUNT*PLANE_BYTES];

	res_t pending_results [$];
	res_t want;

	task automatic note_mismatch(input string what, input int got, input int exp_val);
		$display("%0t mismatch: %s, got %0h, expected %0h", $realtime, what, got, exp_val);
		mismatches++;
	endtask

	// glyph must start inside the plane and its last row must fit
	function automatic bit glyph_fits();
		if (rows_cfg == 0 || int'(off_cfg) > PLANE_BYTES - 4)
			return 1'b0;
		return int'(rows_cfg) <= 1 + (PLANE_BYTES - 4 - int'(off_cfg)) / ROW_PITCH;
	endfunction

	// result of one input transfer, updating page and row position
	function automatic res_t page_outcome(input logic [1:0] act, input logic [31:0] fields);
		res_t        r;
		logic [7:0]  glyph;
		logic [1:0]  plane;
		logic [12:0] addr;
		logic [7:0]  wbyte;
		logic [31:0] mask;
		logic [31:0] word;
		bit          all_set;
		int          base;
		int          p;
		r     = '0;
		glyph = fields[7:0];
		plane = fields[9:8];
		addr  = fields[22:10];
		wbyte = fields[30:23];
		case (act)
			ACT_GLYPH_ROW: begin
				if (!glyph_fits() || row_pos >= rows_cfg) begin
					r.status = 1'b1;
					row_pos  = '0;
				end else begin
					mask    = {glyph, 24'h0} >> mode_cfg[15:12];
					all_set = |(mode_cfg & MODE_SET_BITS);
					for (p = 0; p < PLANE_COUNT; p++) begin
						base = p*PLANE_BYTES + int'(off_cfg) + int'(row_pos)*ROW_PITCH;
						word = {page_copy[base], page_copy[base+1],
						        page_copy[base+2], page_copy[base+3]};
						word = word & ~mask;
						if (all_set || lanes_cfg[p])
							word = word | mask;
						page_copy[base]   = word[31:24];
						page_copy[base+1] = word[23:16];
						page_copy[base+2] = word[15:8];
						page_copy[base+3] = word[7:0];
					end
					row_pos = row_pos + 8'd1;
					if (row_pos >= rows_cfg) begin
						row_pos    = '0;
						r.last_row = 1'b1;
					end
				end
			end
			ACT_WRITE_BYTE, ACT_READ_BYTE: begin
				if (int'(plane) >= PLANE_COUNT || int'(addr) >= PLANE_BYTES) begin
					r.status = 1'b1;
				end else if (act == ACT_WRITE_BYTE) begin
					page_copy[int'(plane)*PLANE_BYTES + int'(addr)] = wbyte;
				end else begin
					r.read_byte = page_copy[int'(plane)*PLANE_BYTES + int'(addr)];
				end
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	// register writes, result compare, then new predictions
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FIRST_OFFSET:  off_cfg   = cfg_data[12:0];
					REG_ROWS_IN_GLYPH: rows_cfg  = cfg_data[7:0];
					REG_SET_LANE_MASK: lanes_cfg = cfg_data[3:0];
					REG_MODE_WORD:     mode_cfg  = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					note_mismatch("result transfer with nothing outstanding",
					              int'({out_status, out_data, out_last}), 0);
				end else begin
					want = pending_results.pop_front();
					if (out_status !== want.status)
						note_mismatch("status", int'(out_status), int'(want.status));
					if (out_data !== want.read_byte)
						note_mismatch("read_byte", int'(out_data), int'(want.read_byte));
					if (out_last !== want.last_row)
						note_mismatch("last_row", int'(out_last), int'(want.last_row));
				end
			end
			if (in_valid && in_ready)
				pending_results.push_back(page_outcome(in_kind, in_data));
		end
		outstanding <= pending_results.size();
	end

endmodule

/* dv/planar_glyph_mask_blit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_glyph_mask_blit_tb
// Drives glyph rows, page byte writes and reads into the blitter under many
// register settings, with random gaps on both streams. Bytes are always
// written before anything reads them; the checker predicts and compares.
// ----------------------------------------------------------------------------
module planar_glyph_mask_blit_tb;
	import pgmb_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS  = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int IDLE_LIMIT    = 2000;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic [1:0]  cfg_index     = '0;
	logic [15:0] cfg_data      = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata  = '0;
	logic [1:0]  s_axis_tuser  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	int mismatches;
	int outstanding;

	// stimulus-side view of registers, row position and loaded bytes
	logic [12:0] cur_off  = '0;
	logic [7:0]  cur_rows = '0;
	int          next_row = 0;
	bit          page_loaded [PLANE_COUNT*PLANE_BYTES];
	int          loaded_list [$];

	int items_driven = 0;
	int n_rows = 0, n_writes = 0, n_reads = 0, n_idle = 0, n_configs = 0;
	int send_calm = 0;
	int quiet_cycles = 0;

	planar_glyph_mask_blit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	planar_glyph_mask_blit_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_data     (s_axis_tdata),
		.in_kind     (s_axis_tuser),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (m_axis_tdata),
		.out_status  (m_axis_tuser),
		.out_last    (m_axis_tlast),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// random stalls on the result stream, with calm stretches
	initial begin
		int hold;
		int calm;
		hold = 0;
		calm = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				m_axis_tready <= 1'b0;
				hold--;
			end else begin
				m_axis_tready <= 1'b1;
				if (calm > 0) begin
					calm--;
				end else begin
					hold = pick_gap();
					if ($urandom_range(0, 99) < 3)
						calm = $urandom_range(20, 80);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("no transfer for %0d cycles", IDLE_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// one input transfer, after a random gap
	task automatic push_item(input logic [1:0] act, input logic [7:0] glyph,
	                         input logic [1:0] plane, input logic [12:0] addr,
	                         input logic [7:0] wbyte);
		int gap;
		if (send_calm > 0) begin
			gap = 0;
			send_calm--;
		end else begin
			gap = pick_gap();
			if ($urandom_range(0, 99) < 3)
				send_calm = $urandom_range(20, 60);
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= {1'b0, wbyte, addr, plane, glyph};
		do @(posedge clk); while (!s_axis_tready);
		case (act)
			ACT_GLYPH_ROW:  n_rows++;
			ACT_WRITE_BYTE: n_writes++;
			ACT_READ_BYTE:  n_reads++;
			default:        n_idle++;
		endcase
		if (act != ACT_UNUSED)
			items_driven++;
	endtask

	// hold off until every result is back and the block has settled
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [12:0] off, input logic [7:0] rows,
	                            input logic [3:0] lanes, input logic [15:0] mode);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= REG_FIRST_OFFSET;
		cfg_data  <= {3'b0, off};
		@(posedge clk);
		cfg_index <= REG_ROWS_IN_GLYPH;
		cfg_data  <= {8'b0, rows};
		@(posedge clk);
		cfg_index <= REG_SET_LANE_MASK;
		cfg_data  <= {12'b0, lanes};
		@(posedge clk);
		cfg_index <= REG_MODE_WORD;
		cfg_data  <= mode;
		@(posedge clk);
		cfg_we   <= 1'b0;
		cur_off  = off;
		cur_rows = rows;
		n_configs++;
	endtask

	task automatic write_page(input logic [1:0] plane, input logic [12:0] addr,
	                          input logic [7:0] data);
		int idx;
		idx = int'(plane)*PLANE_BYTES + int'(addr);
		if (!page_loaded[idx]) begin
			page_loaded[idx] = 1'b1;
			loaded_list.push_back(idx);
		end
		push_item(ACT_WRITE_BYTE, 8'($urandom), plane, addr, data);
	endtask

	task automatic read_at(input logic [1:0] plane, input logic [12:0] addr);
		push_item(ACT_READ_BYTE, 8'($urandom), plane, addr, 8'($urandom));
	endtask

	// read back some byte that is known to hold data
	task automatic read_any();
		int idx;
		if (loaded_list.size() > 0) begin
			idx = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
			read_at(2'(idx / PLANE_BYTES), 13'(idx % PLANE_BYTES));
		end
	endtask

	task automatic idle_item();
		push_item(ACT_UNUSED, 8'($urandom), 2'($urandom), 13'($urandom), 8'($urandom));
	endtask

	function automatic bit glyph_fits_now();
		if (cur_rows == 0 || int'(cur_off) > PLANE_BYTES - 4)
			return 1'b0;
		return int'(cur_rows) <= 1 + (PLANE_BYTES - 4 - int'(cur_off)) / ROW_PITCH;
	endfunction

	// glyph row; the longword it touches in each plane gets loaded first
	task automatic draw_row(input logic [7:0] glyph);
		int p;
		int k;
		int base;
		if (glyph_fits_now() && next_row < int'(cur_rows)) begin
			for (p = 0; p < PLANE_COUNT; p++) begin
				for (k = 0; k < 4; k++) begin
					base = int'(cur_off) + next_row*ROW_PITCH + k;
					if (!page_loaded[p*PLANE_BYTES + base])
						write_page(2'(p), 13'(base), 8'($urandom));
				end
			end
			push_item(ACT_GLYPH_ROW, glyph, 2'($urandom), 13'($urandom), 8'($urandom));
			next_row++;
			if (next_row >= int'(cur_rows))
				next_row = 0;
		end else begin
			push_item(ACT_GLYPH_ROW, glyph, 2'($urandom), 13'($urandom), 8'($urandom));
			next_row = 0;
		end
	endtask

	function automatic logic [15:0] pick_mode();
		int          r;
		logic [15:0] m;
		r = $urandom_range(0, 99);
		m = 16'($urandom);
		if (r < 8)
			return 16'h0000;
		if (r < 16)
			return 16'hFFFF;
		if (r < 50)
			return m & ~MODE_SET_BITS;
		return m;
	endfunction

	// new register setting followed by whole, cut-short and overrun glyphs
	task automatic random_phase();
		logic [12:0] off;
		logic [7:0]  rows;
		int          r;
		int          glyphs;
		int          n;
		r = $urandom_range(0, 99);
		if (r < 6) begin
			rows = 8'd0;
			off  = 13'($urandom);
		end else if (r < 10) begin
			rows = 8'd255;
			off  = 13'($urandom);
		end else if (r < 18) begin
			// tallest glyph that fits, or one row more
			off  = 13'($urandom_range(0, 28));
			rows = (r < 14) ? 8'd206 : 8'd205;
		end else if (r < 22) begin
			rows = 8'($urandom_range(1, 8));
			off  = 13'($urandom_range(PLANE_BYTES - 3, PLANE_BYTES - 1));
		end else if (r < 30) begin
			// near the bottom of the plane, exactly fitting or one row over
			off  = 13'($urandom_range(8000, PLANE_BYTES - 4));
			rows = 8'(1 + (PLANE_BYTES - 4 - int'(off)) / ROW_PITCH
				+ int'($urandom_range(0, 1)));
		end else begin
			rows = 8'($urandom_range(1, 6));
			if ($urandom_range(0, 9) == 0)
				off = 13'(PLANE_BYTES - 4 - (int'(rows) - 1)*ROW_PITCH);
			else
				off = 13'($urandom_range(0, PLANE_BYTES - 4 - (int'(rows) - 1)*ROW_PITCH));
		end
		program_regs(off, rows, 4'($urandom_range(0, 15)), pick_mode());
		glyphs = $urandom_range(1, 4);
		repeat (glyphs) begin
			r = $urandom_range(0, 99);
			if (rows == 0 || rows > 8)
				n = $urandom_range(1, 4);
			else if (r < 75)
				n = int'(rows);
			else
				n = $urandom_range(1, int'(rows) + 2);
			repeat (n) begin
				r = $urandom_range(0, 99);
				if (r < 12)
					write_page(2'($urandom), 13'($urandom), 8'($urandom));
				else if (r < 24)
					read_any();
				else if (r < 27)
					idle_item();
				draw_row(8'($urandom));
			end
			if ($urandom_range(0, 1))
				read_any();
		end
	endtask

	// reset, directed cases, random phases, verdict
	initial begin
		int start_items;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero rows rejects, unused action, byte extremes
		program_regs(13'd0, 8'd0, 4'h0, 16'h0000);
		draw_row(8'hFF);
		push_item(ACT_UNUSED, 8'hFF, 2'd3, 13'h1FFF, 8'hFF);
		write_page(2'd3, 13'h1FFF, 8'hFF);
		write_page(2'd0, 13'h0000, 8'h00);
		read_at(2'd3, 13'h1FFF);
		read_at(2'd0, 13'h0000);

		// one-row glyph at the last longword, lanes decide set or clear
		program_regs(13'(PLANE_BYTES - 4), 8'd1, 4'b0101, 16'h0000);
		draw_row(8'hA5);
		read_at(2'd0, 13'(PLANE_BYTES - 4));
		read_at(2'd1, 13'(PLANE_BYTES - 4));

		// widest shift with set forced in all planes
		program_regs(13'(PLANE_BYTES - 4), 8'd1, 4'h0, 16'hF0F0);
		draw_row(8'hFF);
		read_at(2'd2, 13'(PLANE_BYTES - 3));

		// offset past the last longword
		program_regs(13'(PLANE_BYTES - 3), 8'd1, 4'hF, 16'h0000);
		draw_row(8'h81);

		// tallest glyph, then a count change mid-glyph leaves the row beyond it
		program_regs(13'd0, 8'd205, 4'hF, 16'h0000);
		draw_row(8'h3C);
		draw_row(8'hC3);
		draw_row(8'h00);
		program_regs(13'd0, 8'd2, 4'h3, 16'h1000);
		draw_row(8'hFF);
		draw_row(8'h55);
		draw_row(8'hAA);

		// too many rows for the plane, and the largest count
		program_regs(13'd0, 8'd206, 4'hF, 16'hFFFF);
		draw_row(8'hFF);
		program_regs(13'd0, 8'd255, 4'hF, 16'hFFFF);
		draw_row(8'hFF);

		start_items = items_driven;
		while (items_driven - start_items < RANDOM_ITEMS)
			random_phase();

		drain_results();
		$display("drove %0d glyph rows, %0d byte writes, %0d byte reads, %0d unused actions",
		         n_rows, n_writes, n_reads, n_idle);
		$display("across %0d register settings with random gaps on both streams", n_configs);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/pgmb_pkg.sv
hw/rtl/pgmb_plane_ram.sv
hw/rtl/pgmb_seq.sv
hw/rtl/pgmb_rmw.sv
hw/rtl/pgmb_out_fifo.sv
hw/rtl/planar_glyph_mask_blit.sv
dv/planar_glyph_mask_blit_checker.sv
dv/planar_glyph_mask_blit_tb.sv
